@@ hw/rtl/pbev_pkg.sv @@
// shared types, constants and tables of the pencil back-face edge visibility unit
`default_nettype none

package pbev_pkg;

   localparam int COORD_BITS = 16;
   localparam int NUM_VERTS  = 13;
   localparam int NUM_FACES  = 13;
   localparam int EDGE_COUNT = 24;
   localparam int VIDX_BITS  = 4;
   localparam int FACE_BITS  = 4;
   localparam int UPC_BITS   = 5;
   localparam int LOOP_STEP  = 4;

   // datapath widths
   localparam int VERT_BITS = 3 * COORD_BITS;
   localparam int DIFF_BITS = COORD_BITS + 1;
   localparam int NORM_BITS = 2 * COORD_BITS + 3;
   localparam int LO_BITS   = COORD_BITS + 1;
   localparam int MUL_BITS  = COORD_BITS + 2;
   localparam int PROD_BITS = 2 * MUL_BITS;
   localparam int ACC_BITS  = 3 * COORD_BITS + 4;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_VIEW = 1'b1;

   typedef struct packed {
      logic                   kind;
      logic [VIDX_BITS-1:0]   vertex_index;
      logic signed [15:0]     coord_x;
      logic signed [15:0]     coord_y;
      logic signed [15:0]     coord_z;
   } pbev_req_type;

   typedef struct packed {
      logic [NUM_FACES-1:0]   face_visible;
      logic [EDGE_COUNT-1:0]  edge_visible;
   } pbev_rsp_type;

   typedef enum logic [1:0] {VSEL_0, VSEL_1, VSEL_2} pbev_vsel_type;

   typedef enum logic [1:0] {LAT_NONE, LAT_P0, LAT_A, LAT_B} pbev_lat_type;

   typedef enum logic [3:0] {
      MUL_NONE,
      MUL_BY_AZ, MUL_AY_BZ, MUL_AX_BZ, MUL_BX_AZ, MUL_BX_AY, MUL_AX_BY,
      MUL_NX_LO, MUL_NX_HI, MUL_NY_LO, MUL_NY_HI, MUL_NZ_LO, MUL_NZ_HI
   } pbev_mul_type;

   typedef enum logic [2:0] {ACC_HOLD, ACC_LOAD, ACC_SUB, ACC_ADD, ACC_ADDSH} pbev_acc_type;

   typedef enum logic [1:0] {NST_NONE, NST_X, NST_Y, NST_Z} pbev_nst_type;

   typedef enum logic [1:0] {JMP_NEXT, JMP_LOOP, JMP_END} pbev_jump_type;

   typedef struct packed {
      logic                 rd_en;
      pbev_vsel_type        vsel;
      logic                 rd_next;
      pbev_lat_type         lat;
      pbev_mul_type         mul;
      pbev_acc_type         acc;
      pbev_nst_type         nst;
      logic                 test;
      pbev_jump_type        jump;
      logic [UPC_BITS-1:0]  target;
   } pbev_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } pbev_status_type;

   localparam pbev_ctl_type CTL_NOP = '{
      rd_en:   1'b0,
      vsel:    VSEL_0,
      rd_next: 1'b0,
      lat:     LAT_NONE,
      mul:     MUL_NONE,
      acc:     ACC_HOLD,
      nst:     NST_NONE,
      test:    1'b0,
      jump:    JMP_NEXT,
      target:  '0
   };

   // corners p0, p1, p2 of each face
   function automatic logic [VIDX_BITS-1:0] face_vertex(input logic [FACE_BITS-1:0] face,
                                                        input pbev_vsel_type vsel);
      logic [3*VIDX_BITS-1:0] trio;
      logic [VIDX_BITS-1:0]   v;
      case (face)
         4'd0:    trio = {4'd0,  4'd1,  4'd2};
         4'd1:    trio = {4'd0,  4'd1,  4'd6};
         4'd2:    trio = {4'd1,  4'd2,  4'd7};
         4'd3:    trio = {4'd2,  4'd3,  4'd8};
         4'd4:    trio = {4'd3,  4'd4,  4'd9};
         4'd5:    trio = {4'd4,  4'd5,  4'd10};
         4'd6:    trio = {4'd5,  4'd0,  4'd11};
         4'd7:    trio = {4'd6,  4'd7,  4'd12};
         4'd8:    trio = {4'd7,  4'd8,  4'd12};
         4'd9:    trio = {4'd8,  4'd9,  4'd12};
         4'd10:   trio = {4'd9,  4'd10, 4'd12};
         4'd11:   trio = {4'd10, 4'd11, 4'd12};
         4'd12:   trio = {4'd11, 4'd6,  4'd12};
         default: trio = '0;
      endcase
      case (vsel)
         VSEL_0:  v = trio[3*VIDX_BITS-1:2*VIDX_BITS];
         VSEL_1:  v = trio[2*VIDX_BITS-1:VIDX_BITS];
         VSEL_2:  v = trio[VIDX_BITS-1:0];
         default: v = '0;
      endcase
      return v;
   endfunction

   // edges bordering each face
   function automatic logic [EDGE_COUNT-1:0] face_edges(input logic [FACE_BITS-1:0] face);
      logic [EDGE_COUNT-1:0] e;
      case (face)
         4'd0:    e = 24'h00003F;
         4'd1:    e = 24'h0010C1;
         4'd2:    e = 24'h002182;
         4'd3:    e = 24'h004304;
         4'd4:    e = 24'h008608;
         4'd5:    e = 24'h010C10;
         4'd6:    e = 24'h020860;
         4'd7:    e = 24'h0C1000;
         4'd8:    e = 24'h182000;
         4'd9:    e = 24'h304000;
         4'd10:   e = 24'h608000;
         4'd11:   e = 24'hC10000;
         4'd12:   e = 24'h860000;
         default: e = '0;
      endcase
      return e;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/pencil_backface_edge_visibility_unit.sv @@
// top level of the pencil back-face edge visibility unit
// Usage:
//   req channel carries load beats (kind 0) and view beats (kind 1). A load beat
//   writes one of the 13 stored vertices in its accept cycle; an index above 12
//   is dropped. A load gives no rsp beat.
//   A view beat runs the microcode program over all 13 faces on one shared
//   multiplier: 12 products per face. The rsp beat (face mask and edge mask) is
//   registered once the program ends, and the next req beat can be taken in the
//   cycle that the rsp beat appears, so no view query is taken before the last is through.
//   req_stall stays high while a query is in flight; loads are taken every cycle
//   otherwise, also while a finished rsp beat waits.
//   If rsp_stall holds an earlier result, a finished query waits in its last
//   step until the output register frees up, so nothing is dropped.
//   Reset clears the sequencer and rsp_valid; vertex contents stay undefined
//   until loaded and every vertex a query touches must have been loaded.
`default_nettype none

module pencil_backface_edge_visibility_unit (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire pbev_pkg::pbev_req_type req_payload,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output pbev_pkg::pbev_rsp_type      rsp_payload
);

   import pbev_pkg::*;

   logic                     req_take, start, wr_en, hold;
   logic [COORD_BITS-1:0]    cx, cy, cz;
   pbev_ctl_type             ctl;
   pbev_status_type          status;
   logic [FACE_BITS-1:0]     face;
   logic                     rd_en;
   logic [VIDX_BITS-1:0]     rd_addr;
   logic [VERT_BITS-1:0]     rd_data;
   logic [NUM_FACES-1:0]     face_mask;
   logic [EDGE_COUNT-1:0]    edge_mask;
   logic                     rsp_valid_ff, rsp_valid_in;
   pbev_rsp_type             rsp_payload_ff, rsp_payload_in;

   assign req_stall = status.busy;
   assign req_take  = req_valid && !req_stall;
   assign start     = req_take && (req_payload.kind == KIND_VIEW);
   assign wr_en     = req_take && (req_payload.kind == KIND_LOAD)
                      && (req_payload.vertex_index < VIDX_BITS'(NUM_VERTS));
   assign hold      = rsp_valid_ff && rsp_stall;

   // coordinates live in the low COORD_BITS bits of each field
   assign cx = COORD_BITS'($unsigned(req_payload.coord_x));
   assign cy = COORD_BITS'($unsigned(req_payload.coord_y));
   assign cz = COORD_BITS'($unsigned(req_payload.coord_z));

   pbev_ram #(
      .WIDTH (VERT_BITS),
      .DEPTH (NUM_VERTS)
   ) u_vertex_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (req_payload.vertex_index),
      .wr_data ({cx, cy, cz}),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pbev_sequencer u_sequencer (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .hold    (hold),
      .ctl     (ctl),
      .face    (face),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .status  (status)
   );

   pbev_datapath u_datapath (
      .clock     (clock),
      .start     (start),
      .view_x    (cx),
      .view_y    (cy),
      .view_z    (cz),
      .ctl       (ctl),
      .face      (face),
      .rd_data   (rd_data),
      .face_mask (face_mask),
      .edge_mask (edge_mask)
   );

   always_comb begin
      rsp_valid_in   = hold;
      rsp_payload_in = rsp_payload_ff;
      if (status.done && !hold) begin
         rsp_valid_in                = 1'b1;
         rsp_payload_in.face_visible = face_mask;
         rsp_payload_in.edge_visible = edge_mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   a_rsp_from_program: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(status.done))
      else $error("rsp beat appeared without a finished query");

   a_query_starts: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_payload.kind == KIND_VIEW) |=> status.busy)
      else $error("accepted view beat did not start the program");

   a_result_waits: assert property (@(posedge clock) disable iff (reset)
      (status.done && rsp_valid && rsp_stall) |=> status.busy)
      else $error("finished query left while the output register was full");

endmodule

`default_nettype wire

@@ hw/rtl/pbev_ram.sv @@
// generic single-write, single-read ram with registered read data
`default_nettype none

module pbev_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 13
) (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  wire logic [WIDTH-1:0]          wr_data,
   input  wire logic                      rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]  rd_addr,
   output logic      [WIDTH-1:0]          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hw/rtl/pbev_sequencer.sv @@
// microcode rom, step counter and face counter of the visibility unit
`default_nettype none

module pbev_sequencer (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   input  wire logic                               hold,
   output pbev_pkg::pbev_ctl_type                  ctl,
   output logic [pbev_pkg::FACE_BITS-1:0]          face,
   output logic                                    rd_en,
   output logic [pbev_pkg::VIDX_BITS-1:0]          rd_addr,
   output pbev_pkg::pbev_status_type               status
);

   import pbev_pkg::*;

   // one face takes steps LOOP_STEP..17; steps 13-16 prefetch the next face's corners
   function automatic pbev_ctl_type ucode(input logic [UPC_BITS-1:0] step);
      pbev_ctl_type w;
      w = CTL_NOP;
      case (step)
         5'd0: begin
            w.rd_en = 1'b1; w.vsel = VSEL_0;
         end
         5'd1: begin
            w.rd_en = 1'b1; w.vsel = VSEL_1; w.lat = LAT_P0;
         end
         5'd2: begin
            w.rd_en = 1'b1; w.vsel = VSEL_2; w.lat = LAT_A;
         end
         5'd3: begin
            w.lat = LAT_B;
         end
         5'd4: begin
            w.mul = MUL_BY_AZ;
         end
         5'd5: begin
            w.mul = MUL_AY_BZ; w.acc = ACC_LOAD;
         end
         5'd6: begin
            w.mul = MUL_AX_BZ; w.acc = ACC_SUB;
         end
         5'd7: begin
            w.mul = MUL_BX_AZ; w.acc = ACC_LOAD; w.nst = NST_X;
         end
         5'd8: begin
            w.mul = MUL_BX_AY; w.acc = ACC_SUB;
         end
         5'd9: begin
            w.mul = MUL_AX_BY; w.acc = ACC_LOAD; w.nst = NST_Y;
         end
         5'd10: begin
            w.mul = MUL_NX_LO; w.acc = ACC_SUB;
         end
         5'd11: begin
            w.mul = MUL_NX_HI; w.acc = ACC_LOAD; w.nst = NST_Z;
         end
         5'd12: begin
            w.mul = MUL_NY_LO; w.acc = ACC_ADDSH;
         end
         5'd13: begin
            w.mul = MUL_NY_HI; w.acc = ACC_ADD;
            w.rd_en = 1'b1; w.vsel = VSEL_0; w.rd_next = 1'b1;
         end
         5'd14: begin
            w.mul = MUL_NZ_LO; w.acc = ACC_ADDSH; w.lat = LAT_P0;
            w.rd_en = 1'b1; w.vsel = VSEL_1; w.rd_next = 1'b1;
         end
         5'd15: begin
            w.mul = MUL_NZ_HI; w.acc = ACC_ADD; w.lat = LAT_A;
            w.rd_en = 1'b1; w.vsel = VSEL_2; w.rd_next = 1'b1;
         end
         5'd16: begin
            w.acc = ACC_ADDSH; w.lat = LAT_B;
         end
         5'd17: begin
            w.test = 1'b1; w.jump = JMP_LOOP; w.target = UPC_BITS'(LOOP_STEP);
         end
         5'd18: begin
            w.jump = JMP_END;
         end
         default: begin
            w.jump = JMP_END;
         end
      endcase
      return w;
   endfunction

   logic [UPC_BITS-1:0]  upc_ff, upc_in;
   logic [FACE_BITS-1:0] face_ff, face_in;
   logic                 busy_ff, busy_in;
   pbev_ctl_type         word;
   logic [FACE_BITS-1:0] face_sel;

   assign word = ucode(upc_ff);

   always_comb begin
      upc_in  = upc_ff;
      face_in = face_ff;
      busy_in = busy_ff;
      if (start) begin
         busy_in = 1'b1;
         upc_in  = '0;
         face_in = '0;
      end else if (busy_ff) begin
         if (word.test) begin
            face_in = face_ff + 1'b1;
         end
         case (word.jump)
            JMP_NEXT: begin
               upc_in = upc_ff + 1'b1;
            end
            JMP_LOOP: begin
               upc_in = (face_ff == FACE_BITS'(NUM_FACES - 1)) ? upc_ff + 1'b1 : word.target;
            end
            JMP_END: begin
               if (!hold) begin
                  busy_in = 1'b0;
               end
            end
            default: begin
               upc_in = upc_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff  <= '0;
         face_ff <= '0;
         busy_ff <= 1'b0;
      end else begin
         upc_ff  <= upc_in;
         face_ff <= face_in;
         busy_ff <= busy_in;
      end
   end

   assign face_sel    = word.rd_next ? face_ff + 1'b1 : face_ff;
   assign rd_addr     = face_vertex(face_sel, word.vsel);
   assign rd_en       = busy_ff && word.rd_en;
   assign ctl         = busy_ff ? word : CTL_NOP;
   assign face        = face_ff;
   assign status.busy = busy_ff;
   assign status.done = busy_ff && (word.jump == JMP_END);

   a_face_in_range: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && word.test) |-> (face_ff < FACE_BITS'(NUM_FACES)))
      else $error("facing test on a face past the last one");

   a_start_from_top: assert property (@(posedge clock) disable iff (reset)
      start |=> (busy_ff && upc_ff == '0 && face_ff == '0))
      else $error("program did not restart at step zero");

endmodule

`default_nettype wire

@@ hw/rtl/pbev_datapath.sv @@
// registers, shared multiplier and accumulator that evaluate the facing tests
`default_nettype none

module pbev_datapath (
   input  wire logic                                  clock,
   input  wire logic                                  start,
   input  wire logic [pbev_pkg::COORD_BITS-1:0]       view_x,
   input  wire logic [pbev_pkg::COORD_BITS-1:0]       view_y,
   input  wire logic [pbev_pkg::COORD_BITS-1:0]       view_z,
   input  wire pbev_pkg::pbev_ctl_type                ctl,
   input  wire logic [pbev_pkg::FACE_BITS-1:0]        face,
   input  wire logic [pbev_pkg::VERT_BITS-1:0]        rd_data,
   output logic [pbev_pkg::NUM_FACES-1:0]             face_mask,
   output logic [pbev_pkg::EDGE_COUNT-1:0]            edge_mask
);

   import pbev_pkg::*;

   localparam int C = COORD_BITS;

   logic signed [C-1:0]         cx_ff, cy_ff, cz_ff, cx_in, cy_in, cz_in;
   logic signed [C-1:0]         p0x_ff, p0y_ff, p0z_ff, p0x_in, p0y_in, p0z_in;
   logic signed [C-1:0]         rx, ry, rz;
   logic signed [DIFF_BITS-1:0] dx, dy, dz;
   logic signed [DIFF_BITS-1:0] ax_ff, ay_ff, az_ff, ax_in, ay_in, az_in;
   logic signed [DIFF_BITS-1:0] bx_ff, by_ff, bz_ff, bx_in, by_in, bz_in;
   logic signed [NORM_BITS-1:0] nx_ff, ny_ff, nz_ff, nx_in, ny_in, nz_in;
   logic signed [MUL_BITS-1:0]  op_a, op_b;
   logic signed [PROD_BITS-1:0] prod_ff, prod_in;
   logic signed [ACC_BITS-1:0]  acc_ff, acc_in, prod_ext, prod_sh;
   logic [NUM_FACES-1:0]        fmask_ff, fmask_in;
   logic [EDGE_COUNT-1:0]       emask_ff, emask_in;
   logic                        visible;

   assign rx = rd_data[VERT_BITS-1:2*C];
   assign ry = rd_data[2*C-1:C];
   assign rz = rd_data[C-1:0];

   // corner minus p0, one bit wider
   assign dx = {rx[C-1], rx} - {p0x_ff[C-1], p0x_ff};
   assign dy = {ry[C-1], ry} - {p0y_ff[C-1], p0y_ff};
   assign dz = {rz[C-1], rz} - {p0z_ff[C-1], p0z_ff};

   // normal components go through the multiplier as an unsigned low part and a signed high part
   always_comb begin
      op_a = '0;
      op_b = '0;
      case (ctl.mul)
         MUL_BY_AZ: begin
            op_a = {by_ff[DIFF_BITS-1], by_ff}; op_b = {az_ff[DIFF_BITS-1], az_ff};
         end
         MUL_AY_BZ: begin
            op_a = {ay_ff[DIFF_BITS-1], ay_ff}; op_b = {bz_ff[DIFF_BITS-1], bz_ff};
         end
         MUL_AX_BZ: begin
            op_a = {ax_ff[DIFF_BITS-1], ax_ff}; op_b = {bz_ff[DIFF_BITS-1], bz_ff};
         end
         MUL_BX_AZ: begin
            op_a = {bx_ff[DIFF_BITS-1], bx_ff}; op_b = {az_ff[DIFF_BITS-1], az_ff};
         end
         MUL_BX_AY: begin
            op_a = {bx_ff[DIFF_BITS-1], bx_ff}; op_b = {ay_ff[DIFF_BITS-1], ay_ff};
         end
         MUL_AX_BY: begin
            op_a = {ax_ff[DIFF_BITS-1], ax_ff}; op_b = {by_ff[DIFF_BITS-1], by_ff};
         end
         MUL_NX_LO: begin
            op_a = {1'b0, nx_ff[LO_BITS-1:0]}; op_b = {{2{cx_ff[C-1]}}, cx_ff};
         end
         MUL_NX_HI: begin
            op_a = nx_ff[NORM_BITS-1:LO_BITS]; op_b = {{2{cx_ff[C-1]}}, cx_ff};
         end
         MUL_NY_LO: begin
            op_a = {1'b0, ny_ff[LO_BITS-1:0]}; op_b = {{2{cy_ff[C-1]}}, cy_ff};
         end
         MUL_NY_HI: begin
            op_a = ny_ff[NORM_BITS-1:LO_BITS]; op_b = {{2{cy_ff[C-1]}}, cy_ff};
         end
         MUL_NZ_LO: begin
            op_a = {1'b0, nz_ff[LO_BITS-1:0]}; op_b = {{2{cz_ff[C-1]}}, cz_ff};
         end
         MUL_NZ_HI: begin
            op_a = nz_ff[NORM_BITS-1:LO_BITS]; op_b = {{2{cz_ff[C-1]}}, cz_ff};
         end
         default: begin
            op_a = '0; op_b = '0;
         end
      endcase
   end

   assign prod_in  = op_a * op_b;
   assign prod_ext = {{(ACC_BITS - PROD_BITS){prod_ff[PROD_BITS-1]}}, prod_ff};
   assign prod_sh  = prod_ext << LO_BITS;

   always_comb begin
      case (ctl.acc)
         ACC_LOAD:  acc_in = prod_ext;
         ACC_SUB:   acc_in = acc_ff - prod_ext;
         ACC_ADD:   acc_in = acc_ff + prod_ext;
         ACC_ADDSH: acc_in = acc_ff + prod_sh;
         default:   acc_in = acc_ff;
      endcase
   end

   // back face is seen from below zero, all others from zero up
   assign visible = (face == '0) ? acc_ff[ACC_BITS-1] : !acc_ff[ACC_BITS-1];

   always_comb begin
      cx_in  = cx_ff;  cy_in  = cy_ff;  cz_in  = cz_ff;
      p0x_in = p0x_ff; p0y_in = p0y_ff; p0z_in = p0z_ff;
      ax_in  = ax_ff;  ay_in  = ay_ff;  az_in  = az_ff;
      bx_in  = bx_ff;  by_in  = by_ff;  bz_in  = bz_ff;
      nx_in  = nx_ff;  ny_in  = ny_ff;  nz_in  = nz_ff;
      fmask_in = fmask_ff;
      emask_in = emask_ff;
      case (ctl.lat)
         LAT_P0: begin
            p0x_in = rx; p0y_in = ry; p0z_in = rz;
         end
         LAT_A: begin
            ax_in = dx; ay_in = dy; az_in = dz;
         end
         LAT_B: begin
            bx_in = dx; by_in = dy; bz_in = dz;
         end
         default: begin
            p0x_in = p0x_ff;
         end
      endcase
      case (ctl.nst)
         NST_X:   nx_in = acc_ff[NORM_BITS-1:0];
         NST_Y:   ny_in = acc_ff[NORM_BITS-1:0];
         NST_Z:   nz_in = acc_ff[NORM_BITS-1:0];
         default: nx_in = nx_ff;
      endcase
      if (ctl.test && visible) begin
         fmask_in = fmask_ff | (NUM_FACES'(1) << face);
         emask_in = emask_ff | face_edges(face);
      end
      if (start) begin
         cx_in    = view_x;
         cy_in    = view_y;
         cz_in    = view_z;
         fmask_in = '0;
         emask_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      cx_ff    <= cx_in;  cy_ff  <= cy_in;  cz_ff  <= cz_in;
      p0x_ff   <= p0x_in; p0y_ff <= p0y_in; p0z_ff <= p0z_in;
      ax_ff    <= ax_in;  ay_ff  <= ay_in;  az_ff  <= az_in;
      bx_ff    <= bx_in;  by_ff  <= by_in;  bz_ff  <= bz_in;
      nx_ff    <= nx_in;  ny_ff  <= ny_in;  nz_ff  <= nz_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      fmask_ff <= fmask_in;
      emask_ff <= emask_in;
   end

   assign face_mask = fmask_ff;
   assign edge_mask = emask_ff;

endmodule

`default_nettype wire

@@ tb/pencil_backface_edge_visibility_unit_tb.sv @@
`timescale 1ns / 100ps
// self-checking testbench of the pencil back-face edge visibility unit
module pencil_backface_edge_visibility_unit_tb;
   import pbev_pkg::*;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int ITEM_TARGET  = 950;
   localparam int HOLD_CYCLES  = 600;
   localparam int DRAIN_CYCLES = 200;
   localparam int IDLE_PERCENT = 7;
   localparam int SHOW_LIMIT   = 10;

   class visibility_scoreboard;
      longint       vert_x [NUM_VERTS];
      longint       vert_y [NUM_VERTS];
      longint       vert_z [NUM_VERTS];
      pbev_rsp_type visibility_q[$];
      int unsigned  failures = 0;

      function pbev_rsp_type predict_visibility(pbev_req_type view);
         int           c0, c1, c2, j, f;
         longint       ax, ay, az, bx, by, bz, nx, ny, nz, vx, vy, vz, dot;
         bit           seen;
         pbev_rsp_type res;
         res = '0;
         vx  = view.coord_x;
         vy  = view.coord_y;
         vz  = view.coord_z;
         for (f = 0; f < NUM_FACES; f++) begin
            if (f == 0) begin
               c0 = 0;
               c1 = 1;
               c2 = 2;
            end else if (f <= 6) begin
               c0 = f - 1;
               c1 = f % 6;
               c2 = f + 5;
            end else begin
               c0 = f - 1;
               c1 = 6 + (f - 6) % 6;
               c2 = 12;
            end
            ax  = vert_x[c1] - vert_x[c0];
            ay  = vert_y[c1] - vert_y[c0];
            az  = vert_z[c1] - vert_z[c0];
            bx  = vert_x[c2] - vert_x[c0];
            by  = vert_y[c2] - vert_y[c0];
            bz  = vert_z[c2] - vert_z[c0];
            nx  = by * az - ay * bz;
            ny  = ax * bz - bx * az;
            nz  = bx * ay - ax * by;
            dot = nx * vx + ny * vy + nz * vz;
            // back face faces the viewer on a negative dot, the rest on zero or above
            seen = (f == 0) ? (dot < 0) : (dot >= 0);
            if (seen) begin
               res.face_visible[f] = 1'b1;
               if (f == 0) begin
                  res.edge_visible[5:0] = 6'h3F;
               end else if (f <= 6) begin
                  j = f - 1;
                  res.edge_visible[j]                = 1'b1;
                  res.edge_visible[6 + j]            = 1'b1;
                  res.edge_visible[6 + (j + 1) % 6]  = 1'b1;
                  res.edge_visible[12 + j]           = 1'b1;
               end else begin
                  j = f - 7;
                  res.edge_visible[12 + j]           = 1'b1;
                  res.edge_visible[18 + j]           = 1'b1;
                  res.edge_visible[18 + (j + 1) % 6] = 1'b1;
               end
            end
         end
         return res;
      endfunction

      function void note_beat(pbev_req_type beat);
         if (beat.kind == KIND_VIEW) begin
            visibility_q.push_back(predict_visibility(beat));
         end else if (beat.vertex_index < NUM_VERTS) begin
            vert_x[beat.vertex_index] = beat.coord_x;
            vert_y[beat.vertex_index] = beat.coord_y;
            vert_z[beat.vertex_index] = beat.coord_z;
         end
      endfunction

      function void check_beat(pbev_rsp_type got);
         pbev_rsp_type want;
         if (visibility_q.size() == 0) begin
            failures++;
            if (failures <= SHOW_LIMIT)
               $display("rsp beat with nothing pending: face %h edge %h",
                        got.face_visible, got.edge_visible);
            return;
         end
         want = visibility_q.pop_front();
         if (got.face_visible !== want.face_visible ||
             got.edge_visible !== want.edge_visible) begin
            failures++;
            if (failures <= SHOW_LIMIT)
               $display("rsp mismatch: face exp %h got %h, edge exp %h got %h",
                        want.face_visible, got.face_visible,
                        want.edge_visible, got.edge_visible);
         end
      endfunction
   endclass

   logic         clock       = 1'b0;
   logic         reset       = 1'b1;
   logic         req_valid   = 1'b0;
   logic         req_stall;
   pbev_req_type req_payload = '0;
   logic         rsp_valid;
   logic         rsp_stall   = 1'b0;
   pbev_rsp_type rsp_payload;

   bit           req_idle_on = 1'b1;
   bit           rsp_idle_on = 1'b1;
   bit           hold_kick   = 1'b0;
   int unsigned  cycle_count = 0;
   int unsigned  item_count  = 0;

   visibility_scoreboard board = new();

   pencil_backface_edge_visibility_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("pencil_backface_edge_visibility_unit_tb NOT OK");
         $finish;
      end
   end

   function automatic pbev_req_type make_beat(logic kind, int idx, int x, int y, int z);
      pbev_req_type b;
      b.kind         = kind;
      b.vertex_index = idx[VIDX_BITS-1:0];
      b.coord_x      = x[15:0];
      b.coord_y      = y[15:0];
      b.coord_z      = z[15:0];
      return b;
   endfunction

   function automatic logic signed [15:0] rand_coord();
      logic signed [15:0] c;
      case ($urandom_range(5))
         0:       c = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
         1, 2:    c = 16'($urandom());
         default: c = 16'($urandom_range(400) - 200);
      endcase
      return c;
   endfunction

   task automatic send_beat(input pbev_req_type beat);
      while (req_idle_on && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= beat;
      do @(posedge clock); while (req_stall);
      board.note_beat(beat);
      // loads to a missing vertex are dropped by the block
      if (beat.kind == KIND_VIEW || beat.vertex_index < NUM_VERTS)
         item_count++;
   endtask

   // hexagonal prism with a cone, axis along one of x, y, z
   task automatic load_prism(int r, int z_back, int z_front, int z_tip, int perm, bit jitter_on);
      int hx[6] = '{2, 1, -1, -2, -1, 1};
      int hy[6] = '{0, 2, 2, 0, -2, -2};
      int u, v, w, ju, jv;
      for (int i = 0; i < NUM_VERTS; i++) begin
         ju = jitter_on ? int'($urandom_range(6)) - 3 : 0;
         jv = jitter_on ? int'($urandom_range(6)) - 3 : 0;
         if (i < 12) begin
            u = hx[i % 6] * r + ju;
            v = hy[i % 6] * r + jv;
            w = (i < 6) ? z_back : z_front;
         end else begin
            u = ju;
            v = jv;
            w = z_tip;
         end
         case (perm)
            0:       send_beat(make_beat(KIND_LOAD, i, u, v, w));
            1:       send_beat(make_beat(KIND_LOAD, i, w, u, v));
            default: send_beat(make_beat(KIND_LOAD, i, v, w, u));
         endcase
      end
   endtask

   initial begin : rsp_side
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            board.check_beat(rsp_payload);
         if (hold_kick) begin
            hold_kick = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= rsp_idle_on && ($urandom_range(99) < IDLE_PERCENT);
         end
      end
   end

   initial begin : req_side
      int pick, len, dir, base;
      bit hold_done;
      hold_done = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // plain pencil along +z, every vertex loaded before any view
      load_prism(100, 0, 400, 600, 0, 1'b0);
      send_beat(make_beat(KIND_VIEW, 0, 0, 0, 32767));
      send_beat(make_beat(KIND_VIEW, 0, 0, 0, -32768));
      send_beat(make_beat(KIND_VIEW, 0, 32767, 0, 0));
      // zero view vector: every dot product is zero
      send_beat(make_beat(KIND_VIEW, 0, 0, 0, 0));
      // loads past the last vertex must leave the store alone
      send_beat(make_beat(KIND_LOAD, 13, 32767, -32768, 32767));
      send_beat(make_beat(KIND_LOAD, 14, -32768, 32767, -32768));
      send_beat(make_beat(KIND_LOAD, 15, -1, -1, -1));
      send_beat(make_beat(KIND_VIEW, 15, -32768, 32767, -1));
      // extreme corners
      send_beat(make_beat(KIND_LOAD, 12, 32767, 32767, 32767));
      send_beat(make_beat(KIND_LOAD, 0, -32768, -32768, -32768));
      send_beat(make_beat(KIND_VIEW, 0, 32767, -32768, 32767));
      // coincident corners give a zero normal
      send_beat(make_beat(KIND_LOAD, 1, -32768, -32768, -32768));
      send_beat(make_beat(KIND_VIEW, 0, 1, 2, 3));

      while (item_count < ITEM_TARGET) begin
         if (item_count >= 250 && !hold_done) begin
            hold_kick = 1'b1;
            hold_done = 1'b1;
         end
         req_idle_on = !(item_count >= 450 && item_count < 650);
         rsp_idle_on = req_idle_on;
         pick = $urandom_range(99);
         if (pick < 12) begin
            len  = $urandom_range(8000, 1);
            dir  = $urandom_range(1) ? 1 : -1;
            base = -int'($urandom_range(10000));
            load_prism($urandom_range(5000, 1), dir * base, dir * (base + len),
                       dir * (base + len + int'($urandom_range(4000, 1))),
                       $urandom_range(2), 1'($urandom_range(1)));
         end else if (pick < 55) begin
            send_beat(make_beat(KIND_VIEW, $urandom_range(15),
                                rand_coord(), rand_coord(), rand_coord()));
         end else if (pick < 90) begin
            send_beat(make_beat(KIND_LOAD, $urandom_range(12),
                                rand_coord(), rand_coord(), rand_coord()));
         end else begin
            send_beat(make_beat(KIND_LOAD, $urandom_range(15),
                                rand_coord(), rand_coord(), rand_coord()));
         end
      end
      req_valid <= 1'b0;

      while (board.visibility_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.failures == 0)
         $display("pencil_backface_edge_visibility_unit_tb OK");
      else
         $display("pencil_backface_edge_visibility_unit_tb NOT OK");
      $finish;
   end

endmodule

@@ pencil_backface_edge_visibility_unit.f @@
hw/rtl/pbev_pkg.sv
hw/rtl/pbev_ram.sv
hw/rtl/pbev_sequencer.sv
hw/rtl/pbev_datapath.sv
hw/rtl/pencil_backface_edge_visibility_unit.sv
tb/pencil_backface_edge_visibility_unit_tb.sv
